// ===== hw/rtl/purs_pkg.sv =====
package purs_pkg;

	localparam int MAX_ENTRIES_DEF = 64;
	localparam int ID_W            = 6;
	localparam int CNT_MAX         = 15;

	localparam logic [2:0] CMD_REGISTER = 3'd0;
	localparam logic [2:0] CMD_SET_VIS  = 3'd1;
	localparam logic [2:0] CMD_TICK     = 3'd2;
	localparam logic [2:0] CMD_QUERY    = 3'd3;
	localparam logic [2:0] CMD_FORCE    = 3'd4;

	localparam logic [1:0] STATUS_OK      = 2'd0;
	localparam logic [1:0] STATUS_UNKNOWN = 2'd1;
	localparam logic [1:0] STATUS_FULL    = 2'd2;

	localparam logic [1:0] PRIO_CRITICAL = 2'd0;
	localparam logic [1:0] PRIO_MEDIUM   = 2'd2;
	localparam logic [1:0] PRIO_LOW      = 2'd3;

	localparam logic [1:0] CFG_MEDIUM_INTERVAL = 2'd0;
	localparam logic [1:0] CFG_LOW_INTERVAL    = 2'd1;

	localparam logic [3:0] MEDIUM_IV_RESET = 4'd2;
	localparam logic [3:0] LOW_IV_RESET    = 4'd6;

	typedef struct packed {
		logic [2:0]      command;
		logic [ID_W-1:0] entry_id;
		logic [1:0]      priority_level;
		logic            visible_flag;
		logic            light_present;
	} req_t;

	typedef struct packed {
		logic [1:0]      status;
		logic [ID_W-1:0] assigned_id;
		logic            due_flag;
		logic [6:0]      due_count;
		logic [6:0]      entry_total;
	} rsp_t;

	typedef struct packed {
		logic [1:0] index;
		logic [3:0] data;
	} cfg_t;

	typedef struct packed {
		logic [3:0] medium_iv;
		logic [3:0] low_iv;
	} intervals_t;

	typedef struct packed {
		logic [1:0] prio;
		logic       visible;
		logic       due;
		logic [3:0] waited;
	} entry_t;

	// frame update of one entry; the returned due bit says whether it fired
	function automatic entry_t tick_entry(input entry_t e, input intervals_t iv);
		logic [3:0] ivl;
		entry_t     r;
		case (e.prio)
			PRIO_MEDIUM: ivl = iv.medium_iv;
			PRIO_LOW:    ivl = iv.low_iv;
			default:     ivl = 4'd1;
		endcase
		if (ivl == 4'd0) begin
			ivl = 4'd1;
		end
		r     = e;
		r.due = e.visible && (e.waited >= (ivl - 4'd1));
		if (r.due) begin
			r.waited = 4'd0;
		end else if (e.waited != 4'(CNT_MAX)) begin
			r.waited = e.waited + 4'd1;
		end
		return r;
	endfunction

endpackage

// ===== hw/rtl/purs_stream_if.sv =====
interface purs_stream_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/priority_update_rate_scheduler.sv =====
// Entry table in one synchronous RAM, one item at a time. Register, set visibility,
// query and force read the entry at acceptance and modify and write it back in the
// next cycle. A frame tick walks the RAM one entry per cycle, with the read of the next
// entry overlapped with the write-back of the current one. The result sits in an
// output register, so the next item is taken while it waits. The RAM is not cleared;
// only data read from registered entries is ever used. Interval registers are
// written through the cfg channel.
module priority_update_rate_scheduler #(
	parameter int MAX_ENTRIES = purs_pkg::MAX_ENTRIES_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	purs_stream_if.sink   req,
	purs_stream_if.source rsp,
	purs_stream_if.sink   cfg
);

	localparam int IDX_W = $clog2(MAX_ENTRIES);
	localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
	localparam int CMP_W = (CNT_W > purs_pkg::ID_W) ? CNT_W : purs_pkg::ID_W;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_EXEC = 3'b010,
		S_HOLD = 3'b100
	} state_t;

	state_t               state_q;
	logic [2:0]           cmd_q;
	logic [IDX_W-1:0]     id_q;
	logic                 known_q;
	logic [1:0]           prio_q;
	logic                 vis_q;
	logic                 light_q;
	logic [CNT_W-1:0]     count_q;
	logic [IDX_W-1:0]     proc_q;
	logic [CNT_W-1:0]     due_acc_q;
	logic                 rsp_valid_q;
	purs_pkg::rsp_t       rsp_q;
	purs_pkg::rsp_t       pend_q;

	purs_pkg::intervals_t iv;
	purs_pkg::entry_t     rd_data;
	purs_pkg::entry_t     wr_data;
	logic                 wr_en_c;
	logic                 mem_wr_en;
	logic [IDX_W-1:0]     wr_addr;
	logic                 mem_rd_en;
	logic [IDX_W-1:0]     rd_addr;

	logic                 accept;
	logic                 slot_free;
	logic                 rsp_load;
	logic                 done;
	logic                 exec;
	purs_pkg::rsp_t       res;
	logic [CNT_W-1:0]     count_d;
	logic [IDX_W-1:0]     proc_d;
	logic [CNT_W-1:0]     acc_d;

	purs_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.iv     (iv)
	);

	purs_entry_ram #(.DEPTH(MAX_ENTRIES)) u_ram (
		.clk     (clk),
		.rd_en   (mem_rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (mem_wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	assign req.ready   = (state_q == S_IDLE);
	assign accept      = req.valid && (state_q == S_IDLE);
	assign slot_free   = !rsp_valid_q || rsp.ready;
	assign rsp.valid   = rsp_valid_q;
	assign rsp.payload = rsp_q;
	assign exec        = (state_q == S_EXEC);
	assign rsp_load    = slot_free && ((exec && done) || (state_q == S_HOLD));

	always_comb begin
		mem_rd_en = 1'b0;
		rd_addr   = IDX_W'(req.payload.entry_id);
		if (accept) begin
			mem_rd_en = 1'b1;
			if (req.payload.command == purs_pkg::CMD_TICK) begin
				rd_addr = '0;
			end
		end else if (exec && cmd_q == purs_pkg::CMD_TICK) begin
			mem_rd_en = 1'b1;
			rd_addr   = proc_q + IDX_W'(1);
		end
	end

	always_comb begin
		wr_en_c = 1'b0;
		wr_addr = id_q;
		wr_data = rd_data;
		done    = 1'b0;
		res     = '0;
		count_d = count_q;
		proc_d  = proc_q;
		acc_d   = due_acc_q;
		case (cmd_q)
			purs_pkg::CMD_REGISTER: begin
				done = 1'b1;
				if (!light_q) begin
					res.status = purs_pkg::STATUS_UNKNOWN;
				end else if (count_q == CNT_W'(MAX_ENTRIES)) begin
					res.status = purs_pkg::STATUS_FULL;
				end else begin
					wr_en_c         = 1'b1;
					wr_addr         = IDX_W'(count_q);
					wr_data.prio    = prio_q;
					wr_data.visible = 1'b1;
					wr_data.due     = 1'b1;
					wr_data.waited  = 4'd0;
					res.assigned_id = purs_pkg::ID_W'(count_q);
					count_d         = count_q + CNT_W'(1);
				end
			end
			purs_pkg::CMD_SET_VIS: begin
				done = 1'b1;
				if (known_q) begin
					wr_en_c         = 1'b1;
					wr_data.visible = vis_q;
				end else begin
					res.status = purs_pkg::STATUS_UNKNOWN;
				end
			end
			purs_pkg::CMD_TICK: begin
				if (count_q == '0) begin
					done = 1'b1;
				end else begin
					wr_en_c = 1'b1;
					wr_addr = proc_q;
					wr_data = purs_pkg::tick_entry(rd_data, iv);
					acc_d   = due_acc_q + CNT_W'(wr_data.due);
					if (CNT_W'(proc_q) + CNT_W'(1) == count_q) begin
						done          = 1'b1;
						res.due_count = 7'(acc_d);
					end else begin
						proc_d = proc_q + IDX_W'(1);
					end
				end
			end
			purs_pkg::CMD_QUERY: begin
				done = 1'b1;
				if (known_q) begin
					res.due_flag = rd_data.due;
				end else begin
					res.status = purs_pkg::STATUS_UNKNOWN;
				end
			end
			purs_pkg::CMD_FORCE: begin
				done = 1'b1;
				if (known_q) begin
					wr_en_c        = 1'b1;
					wr_data.due    = 1'b1;
					wr_data.waited = 4'd0;
				end else begin
					res.status = purs_pkg::STATUS_UNKNOWN;
				end
			end
			default: begin
				done = 1'b1;
			end
		endcase
		res.entry_total = 7'(count_d);
	end

	assign mem_wr_en = exec && wr_en_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (done) begin
						count_q <= count_d;
						if (slot_free) begin
							state_q <= S_IDLE;
						end else begin
							state_q <= S_HOLD;
						end
					end
				end
				S_HOLD: begin
					if (slot_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q     <= req.payload.command;
			id_q      <= IDX_W'(req.payload.entry_id);
			known_q   <= CMP_W'(req.payload.entry_id) < CMP_W'(count_q);
			prio_q    <= req.payload.priority_level;
			vis_q     <= req.payload.visible_flag;
			light_q   <= req.payload.light_present;
			proc_q    <= '0;
			due_acc_q <= '0;
		end else if (exec) begin
			proc_q    <= proc_d;
			due_acc_q <= acc_d;
		end
		if (exec && done) begin
			if (slot_free) begin
				rsp_q <= res;
			end else begin
				pend_q <= res;
			end
		end else if (state_q == S_HOLD && slot_free) begin
			rsp_q <= pend_q;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_ENTRIES))
		else $error("entry count beyond table size");

	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == S_EXEC))
		else $error("accepted item not executed");

	a_write_in_exec: assert property (@(posedge clk) disable iff (!arst_n)
		mem_wr_en |-> exec)
		else $error("ram write outside execute");

	a_tick_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(exec && cmd_q == purs_pkg::CMD_TICK && mem_wr_en) |-> (CNT_W'(proc_q) < count_q))
		else $error("tick walk past last entry");

	a_hold_full: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_HOLD) |-> rsp_valid_q)
		else $error("result held while output slot empty");

endmodule

// ===== hw/rtl/purs_cfg_regs.sv =====
module purs_cfg_regs (
	input  logic                   clk,
	input  logic                   arst_n,
	purs_stream_if.sink            cfg,
	output purs_pkg::intervals_t   iv
);

	purs_pkg::intervals_t iv_q;

	assign cfg.ready = 1'b1;
	assign iv        = iv_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iv_q.medium_iv <= purs_pkg::MEDIUM_IV_RESET;
			iv_q.low_iv    <= purs_pkg::LOW_IV_RESET;
		end else if (cfg.valid) begin
			case (cfg.payload.index)
				purs_pkg::CFG_MEDIUM_INTERVAL: iv_q.medium_iv <= cfg.payload.data;
				purs_pkg::CFG_LOW_INTERVAL:    iv_q.low_iv    <= cfg.payload.data;
				default: ;
			endcase
		end
	end

endmodule

// ===== hw/rtl/purs_entry_ram.sv =====
module purs_entry_ram #(
	parameter int DEPTH = purs_pkg::MAX_ENTRIES_DEF
) (
	input  logic                      clk,
	input  logic                      rd_en,
	input  logic [$clog2(DEPTH)-1:0]  rd_addr,
	output purs_pkg::entry_t          rd_data,
	input  logic                      wr_en,
	input  logic [$clog2(DEPTH)-1:0]  wr_addr,
	input  purs_pkg::entry_t          wr_data
);

	purs_pkg::entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule
